### sv/u2u_pkg.sv
package u2u_pkg;

    localparam int OFFSET_WIDTH     = 32;
    localparam int OUT_OFFSET_WIDTH = 32;
    localparam int MAX_RESULTS      = 5;
    localparam int RES_IDX_W        = 3;

    localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

    localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [15:0] SURR_HI_BASE     = 16'hD800;
    localparam logic [15:0] SURR_LO_BASE     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE        = 21'h10000;
    localparam logic [20:0] BMP_MAX          = 21'h0FFFF;

    typedef logic [OFFSET_WIDTH-1:0] offset_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_text;
    } in_beat_t;

    typedef struct packed {
        logic [15:0]                 code_unit;
        logic [OUT_OFFSET_WIDTH-1:0] source_offset;
        logic                        is_sentinel;
        logic                        last_result;
    } out_beat_t;

    typedef out_beat_t [MAX_RESULTS-1:0] result_set_t;

    // results of one byte, loaded into the output queue at once
    typedef struct packed {
        logic [RES_IDX_W-1:0] count;
        result_set_t          entries;
    } res_bundle_t;

    typedef struct packed {
        offset_t     pos;
        offset_t     lead;
        logic [20:0] pcp;
        logic [1:0]  need;
        logic [1:0]  held;
    } dec_state_t;

    // saturating increment by a small amount
    function automatic offset_t sat_inc(input offset_t a, input logic [1:0] k);
        logic [OFFSET_WIDTH:0] s;
        s = {1'b0, a} + (OFFSET_WIDTH+1)'(k);
        return s[OFFSET_WIDTH] ? OFFSET_MAX : s[OFFSET_WIDTH-1:0];
    endfunction

    // clamp an internal offset to the output width
    function automatic logic [OUT_OFFSET_WIDTH-1:0] out_off(input offset_t a);
        logic [63:0] w;
        w = 64'(a);
        return (w > 64'(32'hFFFF_FFFF)) ? '1 : w[OUT_OFFSET_WIDTH-1:0];
    endfunction

endpackage

### sv/utf8_to_utf16_offset_mapper_unit.sv
// path: an accepted byte is held in the input register, then its utf-16 beats are loaded into the output queue
// throughput: one byte per cycle while each byte yields at most one beat and the output is ready;
//   a byte yielding k beats (surrogate pair, error replay, sentinel) holds the input until its last beat leaves
// reset: rst_n async active low clears the decoder state, byte offset and
//   both handshake stages; the first byte after reset starts a text at offset 0
module utf8_to_utf16_offset_mapper_unit
    import u2u_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    // utf-8 byte channel
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_beat_t  byte_beat,
    // utf-16 code unit channel
    output logic      unit_valid,
    input  logic      unit_ready,
    output out_beat_t unit_beat
);

    // input register stage
    logic        ibuf_valid_reg;
    logic        ibuf_valid_next;
    in_beat_t    ibuf_reg;

    // decoder state: byte position, pending lead, partial code point
    dec_state_t  state_reg;
    dec_state_t  state_next;

    res_bundle_t bundle;
    logic        load_ready;
    logic        advance;
    logic        byte_take;

    // the held byte moves into the result stage once the queue can take its beats
    assign advance    = ibuf_valid_reg && load_ready;
    assign byte_ready = !ibuf_valid_reg || advance;
    assign byte_take  = byte_valid && byte_ready;

    always_comb
    begin
        ibuf_valid_next = ibuf_valid_reg;
        if (byte_take)
        begin
            ibuf_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ibuf_valid_next = 1'b0;
        end
    end

    // decode one byte against the current state, all results at once
    u2u_decode u_decode (
        .beat       (ibuf_reg),
        .state      (state_reg),
        .bundle     (bundle),
        .state_next (state_next)
    );

    // serializes up to five beats per byte onto the output channel
    u2u_out_queue u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_en    (advance),
        .bundle     (bundle),
        .load_ready (load_ready),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_beat  (unit_beat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ibuf_valid_reg <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            ibuf_valid_reg <= ibuf_valid_next;
            // state only moves when a byte is committed to the output queue
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_take)
        begin
            ibuf_reg <= byte_beat;
        end
    end

endmodule

### sv/u2u_decode.sv
module u2u_decode
    import u2u_pkg::*;
(
    input  in_beat_t    beat,
    input  dec_state_t  state,
    output res_bundle_t bundle,
    output dec_state_t  state_next
);

    result_set_t          res;
    logic [RES_IDX_W-1:0] n;
    dec_state_t           nxt;
    logic [7:0]           b;
    logic                 last;
    logic                 cont;
    logic [20:0]          pcp_ext;
    logic [20:0]          supp;
    logic [1:0]           need_dec;
    logic                 flush_en;
    logic [1:0]           flush_held;
    logic                 lead_en;
    logic [1:0]           lead_need;
    logic [20:0]          lead_bits;
    offset_t              pos_inc;

    always_comb
    begin
        res        = '0;
        n          = '0;
        nxt        = state;
        b          = beat.data_byte;
        last       = beat.end_of_text;
        cont       = (b[7:6] == 2'b10);
        pcp_ext    = {state.pcp[14:0], b[5:0]};
        supp       = pcp_ext - SUPP_BASE;
        need_dec   = state.need - 2'd1;
        flush_en   = 1'b0;
        flush_held = state.held;
        lead_en    = 1'b0;
        lead_need  = '0;
        lead_bits  = '0;
        pos_inc    = sat_inc(state.pos, 2'd1);

        if (state.need != 2'd0 && cont)
        begin
            nxt.pcp  = pcp_ext;
            nxt.need = need_dec;
            if (need_dec == 2'd0)
            begin
                // sequence complete
                if (pcp_ext <= BMP_MAX)
                begin
                    res[n] = '{pcp_ext[15:0], out_off(state.lead), 1'b0, 1'b0};
                    n = n + 1'b1;
                end
                else
                begin
                    res[n] = '{SURR_HI_BASE + 16'(supp[20:10]), out_off(state.lead),
                               1'b0, 1'b0};
                    n = n + 1'b1;
                    res[n] = '{SURR_LO_BASE + 16'(supp[9:0]), out_off(state.lead),
                               1'b0, 1'b0};
                    n = n + 1'b1;
                end
                nxt.held = '0;
                nxt.pcp  = '0;
            end
            else
            begin
                nxt.held = state.held + 2'd1;
                if (last)
                begin
                    flush_en   = 1'b1;
                    flush_held = state.held + 2'd1;
                end
            end
        end
        else
        begin
            flush_en = (state.need != 2'd0);
            lead_en  = 1'b1;
        end

        // broken sequence: lead and each held continuation give a replacement
        if (flush_en)
        begin
            res[n] = '{REPLACEMENT_CHAR, out_off(state.lead), 1'b0, 1'b0};
            n = n + 1'b1;
            for (int k = 0; k < 3; k++)
            begin
                if (2'(k) < flush_held)
                begin
                    res[n] = '{REPLACEMENT_CHAR,
                               out_off(sat_inc(state.lead, 2'(k + 1))), 1'b0, 1'b0};
                    n = n + 1'b1;
                end
            end
            nxt.need = '0;
            nxt.held = '0;
            nxt.pcp  = '0;
        end

        if (lead_en)
        begin
            if (!b[7])
            begin
                res[n] = '{16'(b), out_off(state.pos), 1'b0, 1'b0};
                n = n + 1'b1;
            end
            else
            begin
                if (b[7:5] == 3'b110)
                begin
                    lead_need = 2'd1;
                    lead_bits = 21'(b[4:0]);
                end
                else if (b[7:4] == 4'b1110)
                begin
                    lead_need = 2'd2;
                    lead_bits = 21'(b[3:0]);
                end
                else if (b[7:3] == 5'b11110)
                begin
                    lead_need = 2'd3;
                    lead_bits = 21'(b[2:0]);
                end

                if (lead_need == 2'd0 || last)
                begin
                    res[n] = '{REPLACEMENT_CHAR, out_off(state.pos), 1'b0, 1'b0};
                    n = n + 1'b1;
                end
                else
                begin
                    nxt.need = lead_need;
                    nxt.held = '0;
                    nxt.pcp  = lead_bits;
                    nxt.lead = state.pos;
                end
            end
        end

        nxt.pos = pos_inc;

        if (last)
        begin
            res[n] = '{16'h0000, out_off(pos_inc), 1'b1, 1'b0};
            n = n + 1'b1;
            nxt = '0;
        end

        if (n != '0)
        begin
            res[n - 1'b1].last_result = 1'b1;
        end

        bundle.count   = n;
        bundle.entries = res;
        state_next     = nxt;
    end

endmodule

### sv/u2u_out_queue.sv
module u2u_out_queue
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_en,
    input  res_bundle_t bundle,
    output logic        load_ready,
    output logic        unit_valid,
    input  logic        unit_ready,
    output out_beat_t   unit_beat
);

    result_set_t          entries_reg;
    logic [RES_IDX_W-1:0] count_reg;
    logic [RES_IDX_W-1:0] count_next;
    logic [RES_IDX_W-1:0] head_reg;
    logic [RES_IDX_W-1:0] head_next;
    logic                 pop;

    assign unit_valid = (count_reg != '0);
    assign unit_beat  = entries_reg[head_reg];
    assign pop        = unit_valid && unit_ready;
    // refill when empty or once the last held beat leaves
    assign load_ready = (count_reg == '0) || (count_reg == RES_IDX_W'(1) && unit_ready);

    always_comb
    begin
        count_next = count_reg;
        head_next  = head_reg;
        if (load_en)
        begin
            count_next = bundle.count;
            head_next  = '0;
        end
        else if (pop)
        begin
            count_next = count_reg - 1'b1;
            head_next  = head_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            entries_reg <= bundle.entries;
        end
    end

endmodule
